// File: design/brpw_pkg.sv
// ---------------------------------------------------------------------------
// brpw_pkg
// Shared types and constants of the bitmap row pixel writer.
// ---------------------------------------------------------------------------
package brpw_pkg;

    localparam int MAX_ROW_WIDTH = 32;
    localparam int MAX_ROWS      = 64;

    localparam int ROW_W     = 32;   // row_bits
    localparam int RWIDTH_W  = 6;    // row_width
    localparam int COORD_W   = 12;   // origin_x, origin_y
    localparam int RIDX_W    = 6;    // row_index
    localparam int CHAN_W    = 8;    // colour components
    localparam int LP_W      = 13;   // line_pixels
    localparam int PB_W      = 3;    // pixel_bytes
    localparam int FMT_W     = 2;    // pixel_format
    localparam int SH_W      = 5;    // field shifts
    localparam int Y_W       = 13;   // origin_y + row_index
    localparam int BASE_W    = LP_W + Y_W;
    localparam int OFF_W     = 27;
    localparam int WORD_W    = 32;
    localparam int COL_W     = 5;    // column counter

    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic [FMT_W-1:0] FMT_8880 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_8888 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_5650 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SHIFT  = 3'd6;

    localparam logic [LP_W-1:0]  RST_LINE_PIXELS = 13'd320;
    localparam logic [PB_W-1:0]  RST_PIXEL_BYTES = 3'd1;
    localparam logic [SH_W-1:0]  RST_RED_SHIFT   = 5'd16;
    localparam logic [SH_W-1:0]  RST_GREEN_SHIFT = 5'd8;
    localparam logic [SH_W-1:0]  RST_BLUE_SHIFT  = 5'd0;
    localparam logic [SH_W-1:0]  RST_SPARE_SHIFT = 5'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN
    } brpw_state_t;

    typedef struct packed {
        logic [LP_W-1:0]  line_pixels;
        logic [PB_W-1:0]  pixel_bytes;
        logic [FMT_W-1:0] pixel_format;
        logic [SH_W-1:0]  red_shift;
        logic [SH_W-1:0]  green_shift;
        logic [SH_W-1:0]  blue_shift;
        logic [SH_W-1:0]  spare_shift;
    } brpw_cfg_t;

    typedef struct packed {
        logic load;    // capture input item
        logic setup;   // form row base address
        logic step;    // advance one column
    } brpw_cmd_t;

    typedef struct packed {
        logic bit_set;    // current column is a set pixel
        logic row_empty;  // no set pixel left in the row
        logic out_free;   // output register can take a write
    } brpw_sts_t;

endpackage

// File: design/brpw_ctrl.sv
// ---------------------------------------------------------------------------
// brpw_ctrl
// Sequencer: accept a row, form its base address, then scan the columns.
// ---------------------------------------------------------------------------
module brpw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  brpw_pkg::brpw_sts_t sts,
    output brpw_pkg::brpw_cmd_t cmd
);
    import brpw_pkg::*;

    brpw_state_t state_reg;
    brpw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.row_empty) begin
                    state_next = ST_IDLE;
                end else if (!sts.bit_set || sts.out_free) begin
                    // clear columns pass without waiting on the output
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/brpw_dp.sv
// ---------------------------------------------------------------------------
// brpw_dp
// Datapath: colour packing, row base multiply, column shifter, output register.
// ---------------------------------------------------------------------------
module brpw_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  brpw_pkg::brpw_cfg_t                cfg,
    input  logic [brpw_pkg::S_DATA_W-1:0]      s_tdata,
    input  brpw_pkg::brpw_cmd_t                cmd,
    output brpw_pkg::brpw_sts_t                sts,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [brpw_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import brpw_pkg::*;

    function automatic logic [WORD_W-1:0] place(input logic [CHAN_W-1:0] v,
                                                input logic [SH_W-1:0] sh);
        logic [WORD_W-1:0] ext;
        ext = {{(WORD_W-CHAN_W){1'b0}}, v};
        return ext << sh;
    endfunction

    // input fields
    logic [ROW_W-1:0]    in_bits;
    logic [RWIDTH_W-1:0] in_width;
    logic [COORD_W-1:0]  in_x;
    logic [COORD_W-1:0]  in_y;
    logic [RIDX_W-1:0]   in_row;
    logic [CHAN_W-1:0]   in_r, in_g, in_b, in_s;

    assign in_bits  = s_tdata[31:0];
    assign in_width = s_tdata[37:32];
    assign in_x     = s_tdata[49:38];
    assign in_y     = s_tdata[61:50];
    assign in_row   = s_tdata[67:62];
    assign in_r     = s_tdata[75:68];
    assign in_g     = s_tdata[83:76];
    assign in_b     = s_tdata[91:84];
    assign in_s     = s_tdata[99:92];

    logic [RWIDTH_W-1:0] width_sat;
    logic [ROW_W-1:0]    aligned;
    logic                row_ok;
    logic [WORD_W-1:0]   word_c;
    logic                keep_c;

    always_comb begin
        width_sat = (in_width > RWIDTH_W'(MAX_ROW_WIDTH)) ? RWIDTH_W'(MAX_ROW_WIDTH) : in_width;
        row_ok    = ({1'b0, in_row} < (RIDX_W+1)'(MAX_ROWS));
        // leftmost pixel to the top bit, bits above the row width fall off
        aligned   = row_ok ? (in_bits << (RWIDTH_W'(ROW_W) - width_sat)) : '0;
        case (cfg.pixel_format)
            FMT_8888: begin
                keep_c = 1'b0;
                word_c = place(in_r, cfg.red_shift) | place(in_g, cfg.green_shift) |
                         place(in_b, cfg.blue_shift) | place(in_s, cfg.spare_shift);
            end
            FMT_5650: begin
                keep_c = 1'b1;
                word_c = (place({3'b000, in_r[7:3]}, cfg.red_shift) |
                          place({2'b00, in_g[7:2]}, cfg.green_shift) |
                          place({3'b000, in_b[7:3]}, cfg.blue_shift)) << 8;
            end
            default: begin
                keep_c = 1'b1;
                word_c = (place(in_r, cfg.red_shift) | place(in_g, cfg.green_shift) |
                          place(in_b, cfg.blue_shift)) << 8;
            end
        endcase
    end

    // row state
    logic [ROW_W-1:0]   bits_reg;
    logic [COORD_W-1:0] x_reg;
    logic [Y_W-1:0]     y_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [COL_W-1:0]   col_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               keep_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg <= aligned;
            x_reg    <= in_x;
            y_reg    <= {1'b0, in_y} + {{(Y_W-RIDX_W){1'b0}}, in_row};
            col_reg  <= '0;
            word_reg <= word_c;
            keep_reg <= keep_c;
        end else if (cmd.step) begin
            bits_reg <= bits_reg << 1;
            col_reg  <= col_reg + 1'b1;
        end
        if (cmd.setup) begin
            base_reg <= {{Y_W{1'b0}}, cfg.line_pixels} * {{LP_W{1'b0}}, y_reg};
        end
    end

    // offset of the current column
    logic [OFF_W-1:0]      lin;
    logic [OFF_W+PB_W-1:0] prod;
    logic [OFF_W-1:0]      off_c;

    always_comb begin
        lin   = {{(OFF_W-BASE_W){1'b0}}, base_reg} +
                {{(OFF_W-COORD_W){1'b0}}, x_reg} +
                {{(OFF_W-COL_W){1'b0}}, col_reg};
        prod  = {{PB_W{1'b0}}, lin} * {{OFF_W{1'b0}}, cfg.pixel_bytes};
        off_c = prod[OFF_W-1:0];
    end

    // output register
    logic              out_valid_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_keep_reg;
    logic              out_last_reg;
    logic              emit;

    assign emit = cmd.step && bits_reg[ROW_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_off_reg  <= off_c;
            out_word_reg <= word_reg;
            out_keep_reg <= keep_reg;
            out_last_reg <= (bits_reg[ROW_W-2:0] == '0);
        end
    end

    assign sts.bit_set   = bits_reg[ROW_W-1];
    assign sts.row_empty = (bits_reg == '0);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-OFF_W-WORD_W){1'b0}}, out_word_reg, out_off_reg};
    assign m_tuser  = out_keep_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: design/bitmap_row_pixel_writer.sv
// ---------------------------------------------------------------------------
// bitmap_row_pixel_writer
// Turns one row of a one-bit bitmap into framebuffer pixel writes.
// ---------------------------------------------------------------------------
//  channel   ports               carries
//  s_        tvalid/tready/tdata one bitmap row with origin and colour
//  m_        tvalid/tready/tdata one pixel write, tuser keep flag, tlast end of row
//  cfg_      wr_en/index/wdata   geometry and colour layout registers
//
//  a row passes a capture state, a setup state for the line_pixels * y multiply,
//  then the scan, one column per cycle through the shifter while no set column
//  waits on the output, and a last scan step that sees the row empty; a row with
//  no set pixel sees it empty at the first scan step.
//  a set column waits while the output register is full and not taken.
//  the next row is taken once the scan has finished; the last write may still wait.
//  reset is synchronous, active low, and restores the register defaults.
module bitmap_row_pixel_writer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row_bits, row_width, origin_x, origin_y, row_index, red, green, blue, spare
    input  logic [brpw_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // byte_offset, pixel_word
    output logic [brpw_pkg::M_DATA_W-1:0]     m_tdata,
    // keep_low_byte
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [brpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brpw_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
    import brpw_pkg::*;

    brpw_cfg_t cfg_reg;
    brpw_cmd_t cmd;
    brpw_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_pixels  <= RST_LINE_PIXELS;
            cfg_reg.pixel_bytes  <= RST_PIXEL_BYTES;
            cfg_reg.pixel_format <= FMT_8880;
            cfg_reg.red_shift    <= RST_RED_SHIFT;
            cfg_reg.green_shift  <= RST_GREEN_SHIFT;
            cfg_reg.blue_shift   <= RST_BLUE_SHIFT;
            cfg_reg.spare_shift  <= RST_SPARE_SHIFT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LINE_PIXELS:  cfg_reg.line_pixels  <= cfg_wdata;
                REG_PIXEL_BYTES:  cfg_reg.pixel_bytes  <= cfg_wdata[PB_W-1:0];
                REG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_wdata[FMT_W-1:0];
                REG_RED_SHIFT:    cfg_reg.red_shift    <= cfg_wdata[SH_W-1:0];
                REG_GREEN_SHIFT:  cfg_reg.green_shift  <= cfg_wdata[SH_W-1:0];
                REG_BLUE_SHIFT:   cfg_reg.blue_shift   <= cfg_wdata[SH_W-1:0];
                REG_SPARE_SHIFT:  cfg_reg.spare_shift  <= cfg_wdata[SH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    brpw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    brpw_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
